[rtl/core/dsft_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsft_pkg
// Shared types and constants for the deduplicating strongest-first table.
// ----------------------------------------------------------------------------
package dsft_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [63:0]       word0;
        logic [63:0]       word1;
        logic [63:0]       word2;
        logic [63:0]       word3;
        logic signed [7:0] strength;
        logic              secure;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load_key;
        logic raise;
        logic append;
        logic rotate;
    } cell_ctrl_t;

endpackage : dsft_pkg
`default_nettype wire

[rtl/core/dsft_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsft_cell
// One table slot. The slots form a ring. During a search the ring rotates one
// place per cycle past the head, where the probe key is compared, except when
// the write flag is set at the head: then the head slot takes the new entry.
// ----------------------------------------------------------------------------
module dsft_cell
    import dsft_pkg::*;
(
    input  wire        clk,
    input  wire        shift,
    input  entry_t     prev,
    input  wire        write_en,
    input  entry_t     write_data,
    output entry_t     data
);

    entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            data_reg <= write_data;
        end
        else if (shift)
        begin
            data_reg <= prev;
        end
    end

    assign data = data_reg;

endmodule : dsft_cell
`default_nettype wire

[rtl/core/dedup_strongest_first_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_strongest_first_table
// Collects scan entries into a deduplicated table and emits it strongest first.
// ----------------------------------------------------------------------------
// An add whose name is not empty, made while the table has room, rotates the
// stored entries once around a ring of cells past a single key comparator. An
// add with an empty name, or one made while the table is full, is dropped in
// the cycle of its start transfer. A finish makes one selection pass around
// the same ring for each result and puts one result out per pass. An empty
// table gives its single result in the cycle right after the start transfer.
// The receiver cannot stall; each result is valid for the one cycle in which
// result_valid is high. busy is high while an add searches or a finish makes
// its passes; a finish keeps it high until the last result is registered, and
// that result is on the ports in the first cycle with busy low.
module dedup_strongest_first_table
    import dsft_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  wire               cmd,
    input  wire [63:0]        name_word0,
    input  wire [63:0]        name_word1,
    input  wire [63:0]        name_word2,
    input  wire [63:0]        name_word3,
    input  wire signed [7:0]  strength,
    input  wire               is_secure,
    output logic              result_valid,
    output logic [63:0]       out_word0,
    output logic [63:0]       out_word1,
    output logic [63:0]       out_word2,
    output logic [63:0]       out_word3,
    output logic signed [7:0] out_strength,
    output logic              out_secure,
    output logic              present,
    output logic              last
);

    entry_t cells [TABLE_DEPTH];
    entry_t cell_in [TABLE_DEPTH];
    logic   cell_wr [TABLE_DEPTH];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             found_reg, found_next;
    logic             fin_reg, fin_next;
    entry_t           probe_reg, probe_next;
    logic [TABLE_DEPTH-1:0] done_reg, done_next;
    logic [POS_W-1:0] best_reg, best_next;
    logic             have_reg, have_next;
    logic             shift;
    entry_t           head_wr;
    logic             head_we;
    logic             res_v_next;
    entry_t           res_next;
    logic             res_p_next, res_l_next;
    logic             res_v_reg, res_p_reg, res_l_reg;
    entry_t           res_reg;
    logic [POS_W-1:0] pos;
    logic [255:0]     raw_name, norm_name;
    logic             ended;
    logic             match;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            assign cell_in[g] = cells[(g+1)%TABLE_DEPTH];
            dsft_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .prev       (cell_in[g]),
                .write_en   (cell_wr[g]),
                .write_data (head_wr),
                .data       (cells[g])
            );
        end
    endgenerate

    always_comb
    begin
        raw_name  = {name_word3, name_word2, name_word1, name_word0};
        norm_name = '0;
        ended     = 1'b0;
        for (int b = 0; b < 32; b++)
        begin
            if (raw_name[8*b +: 8] == 8'd0)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                norm_name[8*b +: 8] = raw_name[8*b +: 8];
            end
        end
    end

    assign match = (cells[0].word0 == probe_reg.word0) && (cells[0].word1 == probe_reg.word1)
                && (cells[0].word2 == probe_reg.word2) && (cells[0].word3 == probe_reg.word3);

    // Ring position of the head relative to insertion order: cell 0 holds entry step.
    assign pos = step_reg[POS_W-1:0];

    always_comb
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            cell_wr[k] = (k == 0) ? head_we : 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        left_next  = left_reg;
        found_next = found_reg;
        fin_next   = 1'b0;
        probe_next = probe_reg;
        done_next  = done_reg;
        best_next  = best_reg;
        have_next  = have_reg;
        shift      = 1'b0;
        head_we    = 1'b0;
        head_wr    = cells[0];
        res_v_next = 1'b0;
        res_next   = res_reg;
        res_p_next = 1'b0;
        res_l_next = 1'b0;
        busy       = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    step_next = '0;
                    if (cmd_t'(cmd) == CMD_FINISH)
                    begin
                        if (count_reg == '0)
                        begin
                            res_v_next = 1'b1;
                            res_next   = '0;
                            res_l_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                            left_next  = count_reg;
                            done_next  = '0;
                            have_next  = 1'b0;
                        end
                    end
                    else if (norm_name[7:0] != 8'd0 && count_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        state_next = ST_SEARCH;
                        found_next = 1'b0;
                        probe_next = '{word0: norm_name[63:0], word1: norm_name[127:64],
                                       word2: norm_name[191:128], word3: norm_name[255:192],
                                       strength: strength, secure: is_secure};
                    end
                end
            end

            ST_SEARCH:
            begin
                // Walk all TABLE_DEPTH slots so the ring ends where it began.
                if (step_reg < count_reg && !found_reg && match)
                begin
                    found_next = 1'b1;
                    head_we    = 1'b1;
                    head_wr    = cells[0];
                    if (probe_reg.strength > cells[0].strength)
                    begin
                        head_wr.strength = probe_reg.strength;
                    end
                end
                else if (step_reg == count_reg && !found_reg && !match)
                begin
                    head_we = 1'b1;
                    head_wr = probe_reg;
                    count_next = count_reg + 1'b1;
                end
                else if (step_reg == count_reg && !found_reg)
                begin
                    head_we = 1'b1;
                    head_wr = probe_reg;
                    count_next = count_reg + 1'b1;
                end
                shift     = !head_we;
                if (head_we)
                begin
                    shift = 1'b0;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(TABLE_DEPTH - 1) && !head_we)
                begin
                    state_next = ST_IDLE;
                end
                if (head_we)
                begin
                    // A write holds the ring in place, so the step count is kept.
                    step_next = step_reg;
                    found_next = 1'b1;
                end
            end

            ST_EMIT:
            begin
                shift = 1'b1;
                if (step_reg < count_reg && !done_reg[pos])
                begin
                    if (!have_reg || cells[0].strength > res_reg.strength)
                    begin
                        have_next = 1'b1;
                        best_next = pos;
                        res_next  = cells[0];
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(TABLE_DEPTH - 1))
                begin
                    step_next             = '0;
                    res_v_next            = 1'b1;
                    res_p_next            = 1'b1;
                    res_l_next            = (left_reg == CNT_W'(1));
                    done_next[best_next]  = 1'b1;
                    have_next             = 1'b0;
                    left_next             = left_reg - 1'b1;
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                        count_next = '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            res_v_reg <= 1'b0;
            step_reg  <= '0;
            found_reg <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            res_v_reg <= res_v_next;
            step_reg  <= step_next;
            found_reg <= found_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        probe_reg <= probe_next;
        done_reg  <= done_next;
        best_reg  <= best_next;
        have_reg  <= have_next;
        res_reg   <= res_next;
        res_p_reg <= res_p_next;
        res_l_reg <= res_l_next;
    end

    assign result_valid = res_v_reg && !fin_reg;
    assign out_word0    = res_reg.word0;
    assign out_word1    = res_reg.word1;
    assign out_word2    = res_reg.word2;
    assign out_word3    = res_reg.word3;
    assign out_strength = res_reg.strength;
    assign out_secure   = res_reg.secure;
    assign present      = res_p_reg;
    assign last         = res_l_reg;

endmodule : dedup_strongest_first_table
`default_nettype wire

[tb/scan_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_table_checker
// Watches the command and result transfers of the scan table, keeps its own
// copy of the deduplicated table, and compares every result with the sorted
// entries that a finish should produce.
// ----------------------------------------------------------------------------
module scan_table_checker
    import dsft_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  wire               busy,
    input  wire               cmd,
    input  wire [63:0]        name_word0,
    input  wire [63:0]        name_word1,
    input  wire [63:0]        name_word2,
    input  wire [63:0]        name_word3,
    input  wire signed [7:0]  strength,
    input  wire               is_secure,
    input  wire               result_valid,
    input  wire [63:0]        out_word0,
    input  wire [63:0]        out_word1,
    input  wire [63:0]        out_word2,
    input  wire [63:0]        out_word3,
    input  wire signed [7:0]  out_strength,
    input  wire               out_secure,
    input  wire               present,
    input  wire               last,
    output int                fail_count,
    output int                pending
);

    typedef struct {
        logic [255:0]      name;
        logic signed [7:0] str;
        logic              sec;
        logic              pres;
        logic              lst;
    } scan_row_t;

    logic [255:0]      held_name [TABLE_DEPTH];
    logic signed [7:0] held_str  [TABLE_DEPTH];
    logic              held_sec  [TABLE_DEPTH];
    int                held_count;
    scan_row_t         sorted_rows [$];

    function automatic logic [255:0] trim_name(input logic [255:0] raw);
        logic [255:0] acc;
        logic         ended;
        acc   = '0;
        ended = 1'b0;
        for (int b = 0; b < 32; b++)
        begin
            if (raw[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                acc[8*b +: 8] = raw[8*b +: 8];
        end
        return acc;
    endfunction

    task automatic add_entry(input logic [255:0] raw, input logic signed [7:0] s,
                             input logic sec);
        logic [255:0] nm;
        nm = trim_name(raw);
        if (nm[7:0] == 8'h00 || held_count >= TABLE_DEPTH)
            return;
        for (int i = 0; i < held_count; i++)
        begin
            if (held_name[i] == nm)
            begin
                if (s > held_str[i])
                    held_str[i] = s;
                return;
            end
        end
        held_name[held_count] = nm;
        held_str[held_count]  = s;
        held_sec[held_count]  = sec;
        held_count++;
    endtask

    task automatic emit_sorted();
        int        order [TABLE_DEPTH];
        int        k;
        int        p;
        scan_row_t r;
        if (held_count == 0)
        begin
            r = '{name: '0, str: '0, sec: 1'b0, pres: 1'b0, lst: 1'b1};
            sorted_rows.push_back(r);
            return;
        end
        for (int i = 0; i < held_count; i++)
            order[i] = i;
        for (int i = 1; i < held_count; i++)
        begin
            k = order[i];
            p = i;
            while (p > 0 && held_str[order[p-1]] < held_str[k])
            begin
                order[p] = order[p-1];
                p--;
            end
            order[p] = k;
        end
        for (int i = 0; i < held_count; i++)
        begin
            r.name = held_name[order[i]];
            r.str  = held_str[order[i]];
            r.sec  = held_sec[order[i]];
            r.pres = 1'b1;
            r.lst  = (i == held_count - 1);
            sorted_rows.push_back(r);
        end
        held_count = 0;
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scan_row_t want;
        logic [255:0] got_name;
        if (!rst_n)
        begin
            held_count = 0;
            fail_count = 0;
            sorted_rows.delete();
            pending = 0;
        end
        else
        begin
            if (result_valid)
            begin
                got_name = {out_word3, out_word2, out_word1, out_word0};
                if (sorted_rows.size() == 0)
                    report_mismatch("result with none expected");
                else
                begin
                    want = sorted_rows.pop_front();
                    if (got_name !== want.name)
                        report_mismatch($sformatf("name %h, want %h", got_name, want.name));
                    if (out_strength !== want.str)
                        report_mismatch($sformatf("strength %0d, want %0d",
                                                  out_strength, want.str));
                    if (out_secure !== want.sec)
                        report_mismatch("secure flag");
                    if (present !== want.pres)
                        report_mismatch("present flag");
                    if (last !== want.lst)
                        report_mismatch("last flag");
                end
            end
            if (start && !busy)
            begin
                if (cmd == CMD_FINISH)
                    emit_sorted();
                else
                    add_entry({name_word3, name_word2, name_word1, name_word0},
                              strength, is_secure);
            end
            pending = sorted_rows.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives add and finish commands into the scan table, with random gaps in most
// random commands, and leaves all checking to the scan table checker.
// ----------------------------------------------------------------------------
module tb_top;
    import dsft_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              cmd;
    logic [63:0]       name_word0;
    logic [63:0]       name_word1;
    logic [63:0]       name_word2;
    logic [63:0]       name_word3;
    logic signed [7:0] strength;
    logic              is_secure;
    logic              result_valid;
    logic [63:0]       out_word0;
    logic [63:0]       out_word1;
    logic [63:0]       out_word2;
    logic [63:0]       out_word3;
    logic signed [7:0] out_strength;
    logic              out_secure;
    logic              present;
    logic              last;
    int                fail_count;
    int                pending;

    logic [255:0]      name_pool [8];
    int                sent;

    dedup_strongest_first_table uut (.*);

    scan_table_checker checker_inst (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [255:0] rand_name();
        logic [255:0] v;
        for (int i = 0; i < 8; i++)
            v[32*i +: 32] = $urandom;
        return v;
    endfunction

    // Random name, sometimes cut short by a zero byte.
    function automatic logic [255:0] pick_name();
        logic [255:0] v;
        int           cut;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = name_pool[$urandom_range(0, 7)];
            5:             v = '0;
            default:       v = rand_name();
        endcase
        if ($urandom_range(0, 2) == 0)
        begin
            cut = $urandom_range(1, 31);
            v[8*cut +: 8] = 8'h00;
        end
        return v;
    endfunction

    // One command transfer; an idle gap may come first when allowed.
    // Called and returning at a falling edge; busy is stable there, so a
    // start raised while busy is low is taken at the next rising edge.
    task automatic issue(input cmd_t c, input logic [255:0] nm,
                         input logic signed [7:0] s, input logic sec,
                         input bit gaps);
        if (gaps)
            while ($urandom_range(0, 99) < 6)
                @(negedge clk);
        while (busy)
            @(negedge clk);
        start      = 1'b1;
        cmd        = c;
        name_word0 = nm[63:0];
        name_word1 = nm[127:64];
        name_word2 = nm[191:128];
        name_word3 = nm[255:192];
        strength   = s;
        is_secure  = sec;
        @(negedge clk);
        start = 1'b0;
        sent++;
    endtask

    task automatic wait_results();
        while (pending != 0 || busy)
            @(negedge clk);
    endtask

    initial
    begin
        logic [255:0] nm;
        start      = 1'b0;
        cmd        = CMD_ADD;
        name_word0 = '0;
        name_word1 = '0;
        name_word2 = '0;
        name_word3 = '0;
        strength   = '0;
        is_secure  = 1'b0;
        sent       = 0;
        rst_n      = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            name_pool[i] = rand_name();
            name_pool[i][7:0] = 8'h41 + i;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty finish, extremes, duplicates, ties, truncation.
        issue(CMD_FINISH, rand_name(), 8'sd5, 1'b1, 0);
        issue(CMD_ADD, '1, -8'sd128, 1'b1, 0);
        issue(CMD_ADD, '1, 8'sd127, 1'b0, 0);
        issue(CMD_ADD, '0, 8'sd100, 1'b1, 0);
        nm = '1;
        nm[8*5 +: 8] = 8'h00;
        issue(CMD_ADD, nm, -8'sd128, 1'b0, 0);
        issue(CMD_ADD, name_pool[0], -8'sd40, 1'b1, 0);
        issue(CMD_ADD, name_pool[1], -8'sd40, 1'b0, 0);
        issue(CMD_ADD, name_pool[0], -8'sd60, 1'b0, 0);
        issue(CMD_FINISH, '0, '0, 1'b0, 0);
        wait_results();
        for (int i = 0; i < 18; i++)
            issue(CMD_ADD, rand_name() | 256'hFF, 8'($urandom_range(0, 3)), i[0], 0);
        issue(CMD_ADD, rand_name() | 256'hFF, 8'sd127, 1'b1, 0);
        issue(CMD_FINISH, '0, '0, 1'b0, 0);
        wait_results();

        // Random: bursts of adds then a finish; middle stretch without gaps.
        while (sent < 210)
        begin
            for (int i = $urandom_range(0, 20); i > 0; i--)
                issue(CMD_ADD, pick_name(), 8'($urandom), 1'($urandom),
                      !(sent > 100 && sent < 150));
            issue(CMD_FINISH, rand_name(), 8'($urandom), 1'($urandom),
                  !(sent > 100 && sent < 150));
            if ($urandom_range(0, 3) == 0)
                wait_results();
        end

        wait_results();
        repeat (300) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
